// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge out of reset
`define PSE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication into the next cycle, checked out of reset
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pse_pkg.sv
// constants, operation and status codes for the positional stack engine
`default_nettype none

package pse_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int FUNC_W    = 3;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// File: rtl/positional_stack_engine_core.sv
// positional stack engine: bounded word stack with push, pop, insert, delete and search
// push, unused codes and every rejected request go from the checks straight to the result
// pop reads the top entry, insert and delete walk the entries moved, an insert on top skips the walk
// search walks down from the top to the match, or over all of the entries if none
// one request at a time: a new beat is taken only after the last result reaches the output register
// reset: synchronous active-low aresetn empties the stack and drops any pending result
`default_nettype none

`include "assert_macros.svh"

module positional_stack_engine_core #(
    parameter int DEPTH = pse_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // func [2:0], value [34:3], position [39:35]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pse_pkg::S_TDATA_W-1:0] s_tdata,
    // result_value [31:0], found_position [36:32], entry_count [41:37],
    // status [44:42], zero pad [47:45]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pse_pkg::M_TDATA_W-1:0] m_tdata
);

    // address and count widths follow the stack depth, the compare width also the position width
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > pse_pkg::POS_W) ? CW : pse_pkg::POS_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0; // waiting for a request beat
    localparam logic [2:0] ST_EXEC = 3'd1; // checks and walk set-up
    localparam logic [2:0] ST_RUN  = 3'd2; // one ram read issued per cycle
    localparam logic [2:0] ST_FIN  = 3'd3; // insert drops the new word in its slot
    localparam logic [2:0] ST_DONE = 3'd4; // hand the result to the output register

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // request and walk payload
    logic [pse_pkg::FUNC_W-1:0]   op_reg, op_next;
    logic [pse_pkg::DATA_W-1:0]   word_reg, word_next;
    logic [pse_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                left_reg, left_next;
    logic [AW-1:0]                pend_addr_reg, pend_addr_next;
    logic [CW-1:0]                prev_addr_reg, prev_addr_next;
    logic [pse_pkg::DATA_W-1:0]   res_value_reg, res_value_next;
    logic [EW-1:0]                res_found_reg, res_found_next;
    logic [pse_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [pse_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ram ports
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [pse_pkg::DATA_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [pse_pkg::DATA_W-1:0] ram_rdata;

    // derived values
    logic          s_accept;
    logic [EW-1:0] cnt_ext, pos_ext, pos_m1, cnt_m1, walk_len;
    logic [EW:0]   cnt_p1;
    logic          is_full, is_empty, ins_bad, del_bad, walk_last;
    logic [AW-1:0] pos_addr, top_addr, cnt_addr, ptr_step;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cnt_ext  = EW'(cnt_reg);
    assign pos_ext  = EW'(pos_reg);
    assign pos_m1   = pos_ext - EW'(1);
    assign cnt_m1   = cnt_ext - EW'(1);
    assign cnt_p1   = {1'b0, cnt_ext} + (EW + 1)'(1);
    // entries from the given position up to the top, inclusive
    assign walk_len = cnt_ext - pos_m1;

    assign is_full  = (cnt_reg == CW'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    // insert may go one above the top, delete only up to the top
    assign ins_bad  = (pos_reg == '0) || ({1'b0, pos_ext} > cnt_p1);
    assign del_bad  = (pos_reg == '0) || (pos_ext > cnt_ext);

    assign pos_addr = pos_m1[AW-1:0];
    assign top_addr = cnt_m1[AW-1:0];
    assign cnt_addr = cnt_ext[AW-1:0];

    // the one stepper: delete walks upwards, everything else walks down from the top
    assign ptr_step  = (op_reg == pse_pkg::OP_DELETE) ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
    assign walk_last = (left_reg == '0);

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        op_next         = op_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        pend_addr_next  = pend_addr_reg;
        prev_addr_next  = prev_addr_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = prev_addr_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next         = s_tdata[2:0];
                    word_next       = s_tdata[34:3];
                    pos_next        = s_tdata[39:35];
                    res_value_next  = '0;
                    res_found_next  = '0;
                    res_status_next = pse_pkg::ST_OK;
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_DONE;
                priority case (op_reg)
                    pse_pkg::OP_PUSH: begin
                        if (is_full) begin
                            res_status_next = pse_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_addr;
                            ram_wdata = word_reg;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    pse_pkg::OP_POP: begin
                        if (is_empty) begin
                            res_status_next = pse_pkg::ST_EMPTY;
                        end else begin
                            ptr_next   = top_addr;
                            left_next  = CW'(1);
                            state_next = ST_RUN;
                        end
                    end
                    pse_pkg::OP_INSERT: begin
                        if (is_full) begin
                            res_status_next = pse_pkg::ST_FULL;
                        end else if (ins_bad) begin
                            res_status_next = pse_pkg::ST_BADPOS;
                        end else begin
                            // each entry from the top down to the position moves up one
                            ptr_next       = top_addr;
                            left_next      = walk_len[CW-1:0];
                            prev_addr_next = cnt_reg;
                            state_next     = (walk_len == '0) ? ST_FIN : ST_RUN;
                        end
                    end
                    pse_pkg::OP_DELETE: begin
                        if (is_empty) begin
                            res_status_next = pse_pkg::ST_EMPTY;
                        end else if (del_bad) begin
                            res_status_next = pse_pkg::ST_BADPOS;
                        end else begin
                            // read the victim, then shift the rest down one
                            ptr_next   = pos_addr;
                            left_next  = walk_len[CW-1:0];
                            state_next = ST_RUN;
                        end
                    end
                    pse_pkg::OP_SEARCH: begin
                        if (is_empty) begin
                            res_status_next = pse_pkg::ST_NOTFOUND;
                        end else begin
                            ptr_next       = top_addr;
                            left_next      = cnt_reg;
                            prev_addr_next = cnt_reg;
                            state_next     = ST_RUN;
                        end
                    end
                    default: begin
                        // unused codes leave everything as it is
                        res_status_next = pse_pkg::ST_OK;
                    end
                endcase
            end

            ST_RUN: begin
                // read side: one address per cycle while entries remain
                if (!walk_last) begin
                    ram_re         = 1'b1;
                    ram_raddr      = ptr_reg;
                    ptr_next       = ptr_step;
                    left_next      = left_reg - CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                end
                // data side: the word read in the previous cycle
                if (pend_reg) begin
                    prev_addr_next = CW'(pend_addr_reg);
                    priority case (op_reg)
                        pse_pkg::OP_POP: begin
                            res_value_next = ram_rdata;
                            cnt_next       = cnt_reg - CW'(1);
                            state_next     = ST_DONE;
                        end
                        pse_pkg::OP_INSERT: begin
                            // lands in the slot read just before it
                            ram_we = 1'b1;
                            if (walk_last) begin
                                state_next = ST_FIN;
                            end
                        end
                        pse_pkg::OP_DELETE: begin
                            if (pend_addr_reg == pos_addr) begin
                                res_value_next = ram_rdata;
                            end else begin
                                ram_we = 1'b1;
                            end
                            if (walk_last) begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            // search: prev address is one above, i.e. the 1-based place
                            if (ram_rdata == word_reg) begin
                                res_found_next  = EW'(prev_addr_reg);
                                res_status_next = pse_pkg::ST_OK;
                                pend_next       = 1'b0;
                                state_next      = ST_DONE;
                            end else if (walk_last) begin
                                res_status_next = pse_pkg::ST_NOTFOUND;
                                state_next      = ST_DONE;
                            end
                        end
                    endcase
                end
            end

            ST_FIN: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_addr;
                ram_wdata  = word_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // wait for the output register to be free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_status_reg, cnt_ext[4:0],
                                     res_found_reg[4:0], res_value_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        pend_addr_reg  <= pend_addr_next;
        prev_addr_reg  <= prev_addr_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // stack storage, written and read once per cycle at most
    pse_ram #(
        .WIDTH (pse_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fill count never passes the depth
    `PSE_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= CW'(DEPTH), "fill count above depth")
    // read data is only awaited during the walk
    `PSE_ASSERT_ALWAYS(a_pend_run, aclk, aresetn, !pend_reg || state_reg == ST_RUN, "read outside walk")
    // an idle engine leaves the fill count alone
    `PSE_ASSERT_NEXT(a_idle_cnt, aclk, aresetn, state_reg == ST_IDLE, $stable(cnt_reg), "count moved while idle")

endmodule

`default_nettype wire

// File: rtl/pse_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pse_ram #(
    parameter int WIDTH = pse_pkg::DATA_W,
    parameter int DEPTH = pse_pkg::DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sim/positional_stack_engine_core_tb.sv
// self-checking testbench for the positional stack engine: stream beats in, predicted replies out
module positional_stack_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int GAP_MAX     = 10;
    localparam int MIX_ITEMS   = 900;
    localparam int MIX_CHUNK   = 60;
    localparam int CYCLE_LIMIT = 400_000;

    // operation codes the block leaves unused
    localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   word;
        logic [POS_W-1:0]    place;
        logic [POS_W-1:0]    count;
        logic [STATUS_W-1:0] status;
    } stack_reply_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // predicted contents of the stack, entry 0 at the bottom
    logic [DATA_W-1:0] stack_words [DEPTH];
    int                stack_fill = 0;

    stack_reply_t replies_due [$];
    int           gap_max       = GAP_MAX;
    int           mismatches    = 0;
    int           beats_sent    = 0;
    int           cycle_count   = 0;
    int           status_seen [5] = '{default: 0};

    positional_stack_engine_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // applies one request to the predicted stack and returns the reply it should give
    function automatic stack_reply_t stack_apply(input logic [FUNC_W-1:0] fn,
                                                 input logic [DATA_W-1:0] word,
                                                 input logic [POS_W-1:0]  pos);
        stack_reply_t r;
        int           p;
        int           i;
        r        = '0;
        r.status = ST_OK;
        p        = int'(pos);
        case (fn)
            OP_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_words[stack_fill] = word;
                    stack_fill++;
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    r.word = stack_words[stack_fill];
                end
            end
            OP_INSERT: begin
                // full takes precedence over a bad position
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > stack_fill + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = stack_fill; i >= p; i--)
                        stack_words[i] = stack_words[i-1];
                    stack_words[p-1] = word;
                    stack_fill++;
                end
            end
            OP_DELETE: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > stack_fill) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.word = stack_words[p-1];
                    for (i = p; i < stack_fill; i++)
                        stack_words[i-1] = stack_words[i];
                    stack_fill--;
                end
            end
            OP_SEARCH: begin
                // walk down from the top, first match wins
                r.status = ST_NOTFOUND;
                for (i = stack_fill; i > 0 && r.place == 0; i--) begin
                    if (stack_words[i-1] == word) begin
                        r.place  = POS_W'(i);
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        r.count = POS_W'(stack_fill);
        return r;
    endfunction

    // random words half the time, else the signed extremes, all ones or small values for repeats
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return DATA_W'($urandom_range(3));
            default: return $urandom();
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                 cycle_count, what, got, want);
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] word,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {pos, word, fn};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        replies_due.push_back(stack_apply(fn, word, pos));
        beats_sent++;
    endtask

    // hold the input side off until every reply has been taken
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // push, or insert at a mostly legal position
    task automatic send_grow();
        logic [POS_W-1:0] pos;
        if ($urandom_range(99) < 45) begin
            send_request(OP_PUSH, pick_word(), POS_W'($urandom_range(31)));
        end else begin
            if ($urandom_range(9) == 0)
                pos = POS_W'($urandom_range(31));
            else
                pos = POS_W'($urandom_range(stack_fill + 1, 1));
            send_request(OP_INSERT, pick_word(), pos);
        end
    endtask

    // pop, or delete at a mostly legal position
    task automatic send_shrink();
        logic [POS_W-1:0] pos;
        if ($urandom_range(99) < 45) begin
            send_request(OP_POP, pick_word(), POS_W'($urandom_range(31)));
        end else begin
            if (stack_fill == 0 || $urandom_range(9) == 0)
                pos = POS_W'($urandom_range(31));
            else
                pos = POS_W'($urandom_range(stack_fill, 1));
            send_request(OP_DELETE, pick_word(), pos);
        end
    endtask

    // search mostly for a word the stack holds, so hits land at every depth
    task automatic send_search();
        logic [DATA_W-1:0] word;
        if (stack_fill > 0 && $urandom_range(2) != 0)
            word = stack_words[$urandom_range(stack_fill - 1)];
        else
            word = pick_word();
        send_request(OP_SEARCH, word, POS_W'($urandom_range(31)));
    endtask

    task automatic test_directed_edges();
        gap_max = 0;
        // empty stack refuses pop and delete, search finds nothing
        send_request(OP_POP,    32'h0,         5'd0);
        send_request(OP_DELETE, 32'h0,         5'd1);
        send_request(OP_SEARCH, 32'h0,         5'd0);
        // signed extremes
        send_request(OP_PUSH,   32'h8000_0000, 5'd0);
        send_request(OP_PUSH,   32'h7fff_ffff, 5'd31);
        send_request(OP_PUSH,   32'hffff_ffff, 5'd0);
        // insert outside 1 to count+1
        send_request(OP_INSERT, 32'h1111_1111, 5'd0);
        send_request(OP_INSERT, 32'h1111_1111, 5'd5);
        send_request(OP_INSERT, 32'h1111_1111, 5'd17);
        // insert at the bottom, at the top and in the middle
        send_request(OP_INSERT, 32'd5,         5'd1);
        send_request(OP_INSERT, 32'd0,         5'd5);
        send_request(OP_INSERT, 32'hdead_beef, 5'd3);
        send_request(OP_SEARCH, 32'hffff_ffff, 5'd0);
        send_request(OP_SEARCH, 32'h1234_5678, 5'd0);
        // duplicate word: topmost copy must be reported
        send_request(OP_PUSH,   32'd5,         5'd0);
        send_request(OP_SEARCH, 32'd5,         5'd0);
        // delete outside 1 to count, then one legal delete
        send_request(OP_DELETE, 32'h0,         5'd0);
        send_request(OP_DELETE, 32'h0,         5'd8);
        send_request(OP_DELETE, 32'h0,         5'd2);
        for (int f = OP_SPARE_FIRST; f <= OP_SPARE_LAST; f++)
            send_request(FUNC_W'(f), 32'hffff_ffff, 5'd31);
        send_request(OP_POP,    32'h0,         5'd0);
    endtask

    // grow to full, knock on the upper bound, then shrink to empty and knock on the lower one
    task automatic test_fill_and_drain(input int rounds);
        for (int n = 0; n < rounds; n++) begin
            gap_max = (n % 2 == 0) ? GAP_MAX : 0;
            while (stack_fill < DEPTH) begin
                if ($urandom_range(5) == 0) send_search();
                else send_grow();
            end
            send_request(OP_PUSH,   pick_word(), 5'd0);
            send_request(OP_INSERT, pick_word(), POS_W'($urandom_range(31)));
            send_request(OP_INSERT, pick_word(), POS_W'($urandom_range(DEPTH, 1)));
            send_search();
            while (stack_fill > 0) begin
                if ($urandom_range(5) == 0) send_search();
                else send_shrink();
            end
            send_request(OP_POP,    pick_word(), 5'd0);
            send_request(OP_DELETE, pick_word(), POS_W'($urandom_range(31)));
            send_search();
        end
    endtask

    // long random mix, the growth bias moves so the fill level wanders over the whole range
    task automatic test_random_mix(input int items);
        int grow_pct;
        int r;
        for (int n = 0; n < items; n++) begin
            if (n % MIX_CHUNK == 0) begin
                gap_max = ($urandom_range(3) == 0) ? 0 : GAP_MAX;
                case ((n / MIX_CHUNK) % 3)
                    0:       grow_pct = 80;
                    1:       grow_pct = 50;
                    default: grow_pct = 20;
                endcase
                if (n != 0 && (n / MIX_CHUNK) % 4 == 0)
                    wait_for_replies();
            end
            r = $urandom_range(99);
            if (r < 4)
                send_request(FUNC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                             pick_word(), POS_W'($urandom_range(31)));
            else if (r < 20)
                send_search();
            else if ($urandom_range(99) < grow_pct)
                send_grow();
            else
                send_shrink();
        end
    endtask

    // result side: random back-pressure, each beat checked against the oldest prediction
    initial begin : reply_checker
        stack_reply_t        due;
        logic [DATA_W-1:0]   got_word;
        logic [POS_W-1:0]    got_place;
        logic [POS_W-1:0]    got_count;
        logic [STATUS_W-1:0] got_status;
        int                  stall;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            got_word   = m_tdata[31:0];
            got_place  = m_tdata[36:32];
            got_count  = m_tdata[41:37];
            got_status = m_tdata[44:42];
            if (replies_due.size() == 0) begin
                flag_mismatch("unexpected result beat", m_tdata[31:0], '0);
            end else begin
                due = replies_due.pop_front();
                if (got_word !== due.word)
                    flag_mismatch("result_value", got_word, due.word);
                if (got_place !== due.place)
                    flag_mismatch("found_position", DATA_W'(got_place), DATA_W'(due.place));
                if (got_count !== due.count)
                    flag_mismatch("entry_count", DATA_W'(got_count), DATA_W'(due.count));
                if (got_status !== due.status)
                    flag_mismatch("status", DATA_W'(got_status), DATA_W'(due.status));
                if (due.status <= ST_NOTFOUND)
                    status_seen[due.status]++;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        wait_for_replies();
        test_fill_and_drain(4);
        test_random_mix(MIX_ITEMS);
        wait_for_replies();
        repeat (DEPTH + 10) @(posedge aclk);
        $display("covered %0d requests: edge cases, fill and drain to both bounds, random mix",
                 beats_sent);
        $display("replies by status: ok %0d, empty %0d, full %0d, bad position %0d, none %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
